FILE: rtl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg: shared types and constants for the character slot pool
// Holds slot geometry, action and status codes, and store port structs.
// ----------------------------------------------------------------------------
`default_nettype none
package ccp_pkg;

  localparam int unsigned SLOTS      = 256;
  localparam int unsigned SLOT_BITS  = 8;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned TOTAL_BITS = 9;
  localparam int unsigned PAT_BITS   = 64;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ACT_ALLOC      = 4'd0,
    ACT_FIND       = 4'd1,
    ACT_RESERVE    = 4'd2,
    ACT_WRITE      = 4'd3,
    ACT_USE        = 4'd4,
    ACT_FREE       = 4'd5,
    ACT_USE_SP     = 4'd6,
    ACT_FREE_SP    = 4'd7,
    ACT_REMAP      = 4'd8,
    ACT_IDENTITY   = 4'd9,
    ACT_MAP_READ   = 4'd10,
    ACT_CLR_COUNTS = 4'd11,
    ACT_CLR_MARKS  = 4'd12
  } ccp_action_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NONE   = 3'd1,
    ST_UNUSED = 3'd2,
    ST_ZERO   = 3'd3,
    ST_FULL   = 3'd4
  } ccp_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CLEAR,
    S_SCAN,
    S_READ,
    S_EVAL_SP,
    S_EVAL_PL,
    S_DONE
  } ccp_state_e;

  typedef struct packed {
    logic [SLOT_BITS-1:0]  addr;
    logic                  pat_we;
    logic [PAT_BITS-1:0]   pat;
    logic                  pl_we;
    logic                  sp_we;
    logic [COUNT_BITS-1:0] cnt;
    logic                  res_we;
    logic                  res;
    logic                  remap_we;
    logic [SLOT_BITS-1:0]  remap;
  } ccp_wr_t;

  typedef struct packed {
    logic [PAT_BITS-1:0]   pat;
    logic [COUNT_BITS-1:0] pl;
    logic [COUNT_BITS-1:0] sp;
    logic                  res;
    logic [SLOT_BITS-1:0]  remap;
  } ccp_rd_t;

endpackage
`default_nettype wire

FILE: rtl/ccp_store.sv
// ----------------------------------------------------------------------------
// ccp_store: per-slot storage of the character slot pool
// Pattern, count, mark and remap memories with one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ccp_store (
  input  wire logic                          clk_i,
  input  wire logic [ccp_pkg::SLOT_BITS-1:0] rd_addr_i,
  input  wire ccp_pkg::ccp_wr_t              wr_i,
  output ccp_pkg::ccp_rd_t                   rd_o
);

  logic [ccp_pkg::PAT_BITS-1:0]   pat_mem   [ccp_pkg::SLOTS];
  logic [ccp_pkg::COUNT_BITS-1:0] pl_mem    [ccp_pkg::SLOTS];
  logic [ccp_pkg::COUNT_BITS-1:0] sp_mem    [ccp_pkg::SLOTS];
  logic                           res_mem   [ccp_pkg::SLOTS];
  logic [ccp_pkg::SLOT_BITS-1:0]  remap_mem [ccp_pkg::SLOTS];

  ccp_pkg::ccp_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.pat_we) begin
      pat_mem[wr_i.addr] <= wr_i.pat;
    end
    if (wr_i.pl_we) begin
      pl_mem[wr_i.addr] <= wr_i.cnt;
    end
    if (wr_i.sp_we) begin
      sp_mem[wr_i.addr] <= wr_i.cnt;
    end
    if (wr_i.res_we) begin
      res_mem[wr_i.addr] <= wr_i.res;
    end
    if (wr_i.remap_we) begin
      remap_mem[wr_i.addr] <= wr_i.remap;
    end
    rd_q.pat   <= pat_mem[rd_addr_i];
    rd_q.pl    <= pl_mem[rd_addr_i];
    rd_q.sp    <= sp_mem[rd_addr_i];
    rd_q.res   <= res_mem[rd_addr_i];
    rd_q.remap <= remap_mem[rd_addr_i];
  end

  assign rd_o = rd_q;

endmodule
`default_nettype wire

FILE: rtl/ccp_seq.sv
// ----------------------------------------------------------------------------
// ccp_seq: sequencer and shared count unit of the character slot pool
// Scans or visits slots, updates counts and totals, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
module ccp_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [3:0]                    action_i,
  input  wire logic [ccp_pkg::SLOT_BITS-1:0] slot_i,
  input  wire logic [ccp_pkg::PAT_BITS-1:0]  pattern_i,
  input  wire logic [ccp_pkg::TOTAL_BITS-1:0] limit_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  output logic [ccp_pkg::SLOT_BITS-1:0]      slot_out_o,
  output logic [ccp_pkg::TOTAL_BITS-1:0]     used_total_o,
  output logic [ccp_pkg::TOTAL_BITS-1:0]     special_total_o,
  output logic [ccp_pkg::SLOT_BITS-1:0]      rd_addr_o,
  output ccp_pkg::ccp_wr_t                   wr_o,
  input  wire ccp_pkg::ccp_rd_t              rd_i
);

  ccp_pkg::ccp_state_e state_q, state_d;
  logic [3:0]                         act_q, act_d;
  logic [ccp_pkg::SLOT_BITS-1:0]      slot_q, slot_d;
  logic [ccp_pkg::PAT_BITS-1:0]       pat_q, pat_d;
  logic [ccp_pkg::SLOT_BITS:0]        idx_q, idx_d;
  logic [ccp_pkg::SLOT_BITS-1:0]      eidx_q, eidx_d, lo_q, lo_d, hi_q, hi_d;
  logic                               ev_q, ev_d;
  logic [2:0]                         st_q, st_d;
  logic [ccp_pkg::SLOT_BITS-1:0]      so_q, so_d;
  logic [ccp_pkg::TOTAL_BITS-1:0]     used_q, used_d, spt_q, spt_d;
  logic                               ov_q, ov_d;
  logic [2:0]                         ost_q, ost_d;
  logic [ccp_pkg::SLOT_BITS-1:0]      oso_q, oso_d;
  logic [ccp_pkg::TOTAL_BITS-1:0]     oused_q, oused_d, ospt_q, ospt_d;

  // Shared count unit: increment that saturates at COUNT_MAX, or decrement.
  logic [ccp_pkg::COUNT_BITS-1:0] unit_in, unit_out;
  logic                           unit_dn;
  logic [2:0]                     pst;

  always_comb begin
    if (unit_dn) begin
      unit_out = unit_in - 1'b1;
    end else if (unit_in == ccp_pkg::COUNT_MAX) begin
      unit_out = unit_in;
    end else begin
      unit_out = unit_in + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    slot_d  = slot_q;
    pat_d   = pat_q;
    idx_d   = idx_q;
    eidx_d  = eidx_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    ev_d    = 1'b0;
    st_d    = st_q;
    so_d    = so_q;
    used_d  = used_q;
    spt_d   = spt_q;
    ov_d    = ov_q && out_stall_i;
    ost_d   = ost_q;
    oso_d   = oso_q;
    oused_d = oused_q;
    ospt_d  = ospt_q;
    rd_addr_o = slot_q;
    wr_o      = '0;
    wr_o.pat  = pat_q;
    wr_o.cnt  = unit_out;
    unit_in   = rd_i.pl;
    unit_dn   = 1'b0;
    pst       = ccp_pkg::ST_OK;
    in_stall_o = (state_q != ccp_pkg::S_IDLE);

    case (state_q)
      ccp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          act_d  = action_i;
          slot_d = slot_i;
          pat_d  = pattern_i;
          idx_d  = '0;
          lo_d   = '0;
          hi_d   = '1;
          st_d   = ccp_pkg::ST_OK;
          so_d   = '0;
          wr_o.addr = slot_i;
          wr_o.pat  = pattern_i;
          case (action_i)
            ccp_pkg::ACT_ALLOC, ccp_pkg::ACT_FIND: begin
              st_d    = ccp_pkg::ST_NONE;
              state_d = ccp_pkg::S_SCAN;
            end
            ccp_pkg::ACT_REMAP: state_d = ccp_pkg::S_SCAN;
            ccp_pkg::ACT_RESERVE: begin
              wr_o.res_we = 1'b1;
              wr_o.res    = 1'b1;
              state_d     = ccp_pkg::S_DONE;
            end
            ccp_pkg::ACT_WRITE: begin
              wr_o.pat_we = 1'b1;
              state_d     = ccp_pkg::S_DONE;
            end
            ccp_pkg::ACT_USE, ccp_pkg::ACT_FREE, ccp_pkg::ACT_USE_SP,
            ccp_pkg::ACT_FREE_SP, ccp_pkg::ACT_MAP_READ: begin
              state_d = ccp_pkg::S_READ;
            end
            ccp_pkg::ACT_IDENTITY, ccp_pkg::ACT_CLR_MARKS: begin
              state_d = ccp_pkg::S_CLEAR;
            end
            ccp_pkg::ACT_CLR_COUNTS: begin
              used_d  = '0;
              spt_d   = '0;
              state_d = ccp_pkg::S_CLEAR;
            end
            default: state_d = ccp_pkg::S_DONE;
          endcase
        end
      end

      ccp_pkg::S_INIT: begin
        // After reset every slot is written back to its reset contents.
        rd_addr_o     = idx_q[ccp_pkg::SLOT_BITS-1:0];
        wr_o.addr     = idx_q[ccp_pkg::SLOT_BITS-1:0];
        wr_o.pat_we   = 1'b1;
        wr_o.pat      = '0;
        wr_o.pl_we    = 1'b1;
        wr_o.sp_we    = 1'b1;
        wr_o.cnt      = '0;
        wr_o.res_we   = 1'b1;
        wr_o.res      = 1'b0;
        wr_o.remap_we = 1'b1;
        wr_o.remap    = idx_q[ccp_pkg::SLOT_BITS-1:0];
        idx_d         = idx_q + 1'b1;
        if (idx_q[ccp_pkg::SLOT_BITS-1:0] == '1) begin
          state_d = ccp_pkg::S_IDLE;
        end
      end

      ccp_pkg::S_CLEAR: begin
        // One slot a cycle is cleared, or given its identity remap, for the whole-pool actions.
        rd_addr_o = idx_q[ccp_pkg::SLOT_BITS-1:0];
        wr_o.addr = idx_q[ccp_pkg::SLOT_BITS-1:0];
        wr_o.cnt  = '0;
        idx_d     = idx_q + 1'b1;
        case (act_q)
          ccp_pkg::ACT_IDENTITY: begin
            wr_o.remap_we = 1'b1;
            wr_o.remap    = idx_q[ccp_pkg::SLOT_BITS-1:0];
          end
          ccp_pkg::ACT_CLR_COUNTS: begin
            wr_o.pl_we = 1'b1;
            wr_o.sp_we = 1'b1;
          end
          default: begin
            wr_o.res_we = 1'b1;
            wr_o.res    = 1'b0;
          end
        endcase
        if (idx_q[ccp_pkg::SLOT_BITS-1:0] == '1) begin
          state_d = ccp_pkg::S_DONE;
        end
      end

      ccp_pkg::S_SCAN: begin
        // Reads are issued one slot ahead of the evaluation.
        rd_addr_o = idx_q[ccp_pkg::SLOT_BITS-1:0];
        idx_d     = idx_q + 1'b1;
        ev_d      = !idx_q[ccp_pkg::SLOT_BITS];
        eidx_d    = idx_q[ccp_pkg::SLOT_BITS-1:0];
        wr_o.addr = eidx_q;
        if (ev_q) begin
          if (eidx_q == '1) begin
            state_d = ccp_pkg::S_DONE;
          end
          case (act_q)
            ccp_pkg::ACT_ALLOC: begin
              if (rd_i.pl == '0 && !rd_i.res) begin
                wr_o.pat_we = 1'b1;
                st_d        = ccp_pkg::ST_OK;
                so_d        = eidx_q;
                state_d     = ccp_pkg::S_DONE;
              end
            end
            ccp_pkg::ACT_FIND: begin
              if (rd_i.pat == pat_q) begin
                st_d    = ccp_pkg::ST_OK;
                so_d    = eidx_q;
                state_d = ccp_pkg::S_DONE;
              end
            end
            default: begin
              wr_o.remap_we = 1'b1;
              if (rd_i.sp != '0) begin
                wr_o.remap = lo_q;
                lo_d       = lo_q + 1'b1;
              end else begin
                wr_o.remap = hi_q;
                hi_d       = hi_q - 1'b1;
              end
            end
          endcase
        end
      end

      ccp_pkg::S_READ: begin
        if (act_q == ccp_pkg::ACT_USE_SP || act_q == ccp_pkg::ACT_FREE_SP) begin
          state_d = ccp_pkg::S_EVAL_SP;
        end else begin
          state_d = ccp_pkg::S_EVAL_PL;
        end
      end

      ccp_pkg::S_EVAL_SP: begin
        wr_o.addr = slot_q;
        unit_in   = rd_i.sp;
        unit_dn   = (act_q == ccp_pkg::ACT_FREE_SP);
        state_d   = ccp_pkg::S_EVAL_PL;
        if (unit_dn) begin
          if (rd_i.sp == '0) begin
            st_d = ccp_pkg::ST_UNUSED;
          end else begin
            wr_o.sp_we = 1'b1;
            if (unit_out == '0) begin
              if (spt_q == '0) begin
                st_d = ccp_pkg::ST_ZERO;
              end else begin
                spt_d = spt_q - 1'b1;
              end
            end
          end
        end else if (rd_i.sp == '0 && spt_q == limit_i) begin
          st_d    = ccp_pkg::ST_FULL;
          state_d = ccp_pkg::S_DONE;
        end else begin
          wr_o.sp_we = 1'b1;
          if (rd_i.sp == '0) begin
            spt_d = spt_q + 1'b1;
          end
        end
      end

      ccp_pkg::S_EVAL_PL: begin
        wr_o.addr = slot_q;
        unit_in   = rd_i.pl;
        unit_dn   = (act_q == ccp_pkg::ACT_FREE || act_q == ccp_pkg::ACT_FREE_SP);
        state_d   = ccp_pkg::S_DONE;
        if (act_q == ccp_pkg::ACT_MAP_READ) begin
          so_d = rd_i.remap;
        end else begin
          if (unit_dn) begin
            if (rd_i.pl == '0) begin
              pst = ccp_pkg::ST_UNUSED;
            end else begin
              wr_o.pl_we = 1'b1;
              if (unit_out == '0) begin
                if (used_q == '0) begin
                  pst = ccp_pkg::ST_ZERO;
                end else begin
                  used_d = used_q - 1'b1;
                end
              end
            end
          end else begin
            wr_o.pl_we = 1'b1;
            if (rd_i.pl == '0) begin
              used_d = used_q + 1'b1;
            end
          end
          if (st_q == ccp_pkg::ST_OK) begin
            st_d = pst;
          end
        end
      end

      ccp_pkg::S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          ost_d   = st_q;
          oso_d   = so_q;
          oused_d = used_q;
          ospt_d  = spt_q;
          state_d = ccp_pkg::S_IDLE;
        end
      end

      default: state_d = ccp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccp_pkg::S_INIT;
      idx_q   <= '0;
      ev_q    <= 1'b0;
      used_q  <= '0;
      spt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ev_q    <= ev_d;
      used_q  <= used_d;
      spt_q   <= spt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    slot_q  <= slot_d;
    pat_q   <= pat_d;
    eidx_q  <= eidx_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    st_q    <= st_d;
    so_q    <= so_d;
    ost_q   <= ost_d;
    oso_q   <= oso_d;
    oused_q <= oused_d;
    ospt_q  <= ospt_d;
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign slot_out_o      = oso_q;
  assign used_total_o    = oused_q;
  assign special_total_o = ospt_q;

endmodule
`default_nettype wire

FILE: rtl/refcounted_char_slot_pool_core.sv
// ----------------------------------------------------------------------------
// refcounted_char_slot_pool_core: reference counted character slot pool
// Alloc, find and remap scan one slot per cycle over the store's single read port;
// identity map, clear counts and clear marks sweep every slot.
// Use, free, their special forms and map read read the slot and then evaluate it.
// One item is in work at a time. After reset a pass writes every slot
// back to its reset contents while the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module refcounted_char_slot_pool_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  action_i,
  input  wire logic [7:0]  slot_i,
  input  wire logic [63:0] pattern_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [7:0]       slot_out_o,
  output logic [8:0]       used_total_o,
  output logic [8:0]       special_total_o
);

  // The special limit register; a first special use of a slot is refused while
  // the special total equals it.
  logic [8:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 9'd63;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  logic [7:0]         rd_addr;
  ccp_pkg::ccp_wr_t   wr;
  ccp_pkg::ccp_rd_t   rd;

  // The store holds every per-slot field; each memory reads one slot a cycle.
  ccp_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  // The sequencer walks the slots, runs the shared count unit and holds the
  // result register, so a new transfer can be taken while a result waits.
  ccp_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .slot_i          (slot_i),
    .pattern_i       (pattern_i),
    .limit_i         (limit_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .slot_out_o      (slot_out_o),
    .used_total_o    (used_total_o),
    .special_total_o (special_total_o),
    .rd_addr_o       (rd_addr),
    .wr_o            (wr),
    .rd_i            (rd)
  );

endmodule
`default_nettype wire
